// ===== design/rau_pkg.sv =====
// Shared types and codes for the rational arithmetic unit.
// Used by rau_ctrl, rau_dp and rational_arith_unit; no dependencies.
`default_nettype none
package rau_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  typedef enum logic [1:0] {
    MS_A = 2'd0,
    MS_B = 2'd1,
    MS_C = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     prep;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
    logic     fin;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic quick;
    logic gcd_eq;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== design/rau_ctrl.sv =====
// Sequencer for the rational arithmetic unit.
// Depends on rau_pkg; drives rau_dp through dp_cmd_t.
`default_nettype none
module rau_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  rau_pkg::dp_sts_t sts,
  output rau_pkg::dp_cmd_t cmd
);
  import rau_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL0 = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_PREP = 9'b000010000,
    S_GCD  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MS_A;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_A;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_B;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_C;
        state_next  = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_GCD;
      end
      S_GCD: begin
        if (sts.quick) begin
          state_next = S_DONE;
        end else if (sts.gcd_eq) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/rau_dp.sv =====
// Datapath: shared multiplier, binary GCD, twin restoring dividers, output register.
// Depends on rau_pkg; sequenced by rau_ctrl.
`default_nettype none
module rau_dp #(
  parameter int W = 32
) (
  input  wire               clk,
  input  wire               rst,
  input  rau_pkg::dp_cmd_t  cmd,
  output rau_pkg::dp_sts_t  sts,
  input  wire [2:0]         operation,
  input  wire [31:0]        a_num,
  input  wire [30:0]        a_den,
  input  wire [31:0]        b_num,
  input  wire [30:0]        b_den,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [31:0]       res_num,
  output logic [30:0]       res_den,
  output logic [1:0]        order,
  output logic [1:0]        status
);
  import rau_pkg::*;

  localparam int PW = 2 * W + 1;
  localparam int MW = 2 * W;
  localparam int KW = $clog2(MW);
  localparam int CW = $clog2(MW + 1);
  localparam logic [MW-1:0] LIM = MW'(1) << (W - 1);

  logic [2:0]            op_r;
  logic signed [W-1:0]   an_r, bn_r;
  logic [W-2:0]          ad_r, bd_r;
  logic signed [PW-1:0]  pa, pb, pc;

  logic signed [W:0]     mx, my;
  logic signed [2*W+1:0] prod;

  logic signed [PW-1:0]  n_val, n_abs, d_abs;
  logic [MW-1:0]         nm, dm;
  logic                  neg, err;
  logic [1:0]            cmp_ord;

  logic                  quick, neg_r;
  logic [MW-1:0]         nm_r, dm_r, u, v;
  logic [KW-1:0]         k;
  logic [MW-1:0]         qa, qb, ra, rb;
  logic [MW:0]           ta, tb;
  logic [CW-1:0]         cnt;

  logic signed [W-1:0]   res_num_r;
  logic [W-2:0]          res_den_r;
  logic [1:0]            ord_r, st_r;
  logic                  den_ovf, num_ovf;

  // operand load
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= operation;
      an_r <= a_num[W-1:0];
      ad_r <= a_den[W-2:0];
      bn_r <= b_num[W-1:0];
      bd_r <= b_den[W-2:0];
    end
  end

  // one signed multiplier, three passes
  always_comb begin
    case (cmd.mul_sel)
      MS_A: begin
        mx = (W+1)'(an_r);
        my = (op_r == OP_MUL) ? (W+1)'(bn_r) : (W+1)'(bd_r);
      end
      MS_B: begin
        mx = (W+1)'(bn_r);
        my = (W+1)'(ad_r);
      end
      default: begin
        mx = (W+1)'(ad_r);
        my = (op_r == OP_DIV) ? (W+1)'(bn_r) : (W+1)'(bd_r);
      end
    endcase
    prod = mx * my;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MS_A:    pa <= prod[PW-1:0];
        MS_B:    pb <= prod[PW-1:0];
        default: pc <= prod[PW-1:0];
      endcase
    end
  end

  // combine cross products, split sign and magnitude
  always_comb begin
    case (op_r)
      OP_ADD:  n_val = pa + pb;
      OP_SUB:  n_val = pa - pb;
      default: n_val = pa;
    endcase
    n_abs = n_val[PW-1] ? -n_val : n_val;
    d_abs = pc[PW-1] ? -pc : pc;
    nm    = n_abs[MW-1:0];
    dm    = d_abs[MW-1:0];
    neg   = n_val[PW-1] ^ pc[PW-1];
    err   = (ad_r == '0) || (bd_r == '0) || ((op_r == OP_DIV) && (bn_r == '0));
    if (pa < pb) begin
      cmp_ord = ORD_LT;
    end else if (pa == pb) begin
      cmp_ord = ORD_EQ;
    end else begin
      cmp_ord = ORD_GT;
    end
  end

  always_comb begin
    ta = {ra, qa[MW-1]};
    tb = {rb, qb[MW-1]};
    den_ovf = |qb[MW-1:W-1];
    num_ovf = neg_r ? (qa > LIM) : (|qa[MW-1:W-1]);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      quick     <= 1'b1;
      res_num_r <= '0;
      res_den_r <= '0;
      ord_r     <= ORD_LT;
      st_r      <= ST_OK;
      nm_r      <= nm;
      dm_r      <= dm;
      u         <= nm;
      v         <= dm;
      k         <= '0;
      neg_r     <= neg;
      if (op_r == OP_CMP) begin
        ord_r <= cmp_ord;
      end else if (op_r > OP_CMP) begin
        ord_r <= ORD_LT;
      end else if (err) begin
        st_r <= ST_DIVZ;
      end else if (nm == '0) begin
        res_den_r <= (W-1)'(1);
      end else begin
        quick <= 1'b0;
      end
    end else if (cmd.gcd_step) begin
      // binary GCD: common factors of two go to k
      if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + KW'(1);
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u > v) begin
        u <= (u - v) >> 1;
      end else begin
        v <= (v - u) >> 1;
      end
    end else if (cmd.div_init) begin
      // divide by g = u << k: shift out k first, then divide by u
      qa  <= nm_r >> k;
      qb  <= dm_r >> k;
      ra  <= '0;
      rb  <= '0;
      cnt <= CW'(MW);
    end else if (cmd.div_step) begin
      if (ta >= {1'b0, u}) begin
        ra <= MW'(ta - {1'b0, u});
        qa <= {qa[MW-2:0], 1'b1};
      end else begin
        ra <= ta[MW-1:0];
        qa <= {qa[MW-2:0], 1'b0};
      end
      if (tb >= {1'b0, u}) begin
        rb <= MW'(tb - {1'b0, u});
        qb <= {qb[MW-2:0], 1'b1};
      end else begin
        rb <= tb[MW-1:0];
        qb <= {qb[MW-2:0], 1'b0};
      end
      cnt <= cnt - CW'(1);
    end else if (cmd.fin) begin
      if (den_ovf || num_ovf) begin
        res_num_r <= '0;
        res_den_r <= '0;
        st_r      <= ST_OVF;
      end else begin
        res_num_r <= neg_r ? -qa[W-1:0] : qa[W-1:0];
        res_den_r <= qb[W-2:0];
        st_r      <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_num <= 32'(res_num_r);
      res_den <= 31'(res_den_r);
      order   <= ord_r;
      status  <= st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.quick    = quick;
  assign sts.gcd_eq   = (u == v);
  assign sts.div_last = (cnt == CW'(1));
  assign sts.out_free = !out_valid || !out_stall;

`ifndef SYNTHESIS
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.gcd_step |-> (u != '0) && (v != '0))
    else $error("gcd operand reached zero");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (ra < u) && (rb < u))
    else $error("divider remainder not below divisor");

  a_den_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> (st_r != ST_OK) || (res_den_r != '0))
    else $error("ok result with zero denominator");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("output register overwritten while held");
`endif

endmodule
`default_nettype wire

// ===== design/rational_arith_unit.sv =====
// Top level of the rational arithmetic unit: sequencer plus datapath.
// Depends on rau_pkg, rau_ctrl and rau_dp.
//
//   channel | handshake           | payload
//   input   | in_valid / in_stall  | operation, a_num, a_den, b_num, b_den
//   output  | out_valid/out_stall | res_num, res_den, order, status
//
// One item at a time. Compare, unused codes, errors and zero results skip the
// binary GCD and the divider; other items run up to about 4*VALUE_WIDTH binary GCD
// steps, then 2*VALUE_WIDTH divider steps. The GCD loop and the shared dividers set the run time.
// Synchronous reset clears control only. A held result sits in the output
// register while the next item already runs; the finished item waits if it is still held.
`default_nettype none
module rational_arith_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  operation,
  input  wire  [31:0] a_num,
  input  wire  [30:0] a_den,
  input  wire  [31:0] b_num,
  input  wire  [30:0] b_den,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] res_num,
  output logic [30:0] res_den,
  output logic [1:0]  order,
  output logic [1:0]  status
);
  import rau_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rau_dp #(
    .W (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .operation (operation),
    .a_num     (a_num),
    .a_den     (a_den),
    .b_num     (b_num),
    .b_den     (b_den),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_num   (res_num),
    .res_den   (res_den),
    .order     (order),
    .status    (status)
  );

endmodule
`default_nettype wire

// ===== verif/rational_arith_unit_tb.sv =====
// Self-checking testbench for rational_arith_unit: random and directed fraction
// operations checked against an in-bench predictor. Depends on rau_pkg and the RTL.
`default_nettype none
module rational_arith_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] an;
    logic [30:0] ad;
    logic [31:0] bn;
    logic [30:0] bd;
  } frac_op_t;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  ord;
    logic [1:0]  st;
  } frac_res_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic [2:0] operation = 0;
  logic [31:0] a_num = 0, b_num = 0;
  logic [30:0] a_den = 0, b_den = 0;
  wire in_stall, out_valid;
  wire [31:0] res_num;
  wire [30:0] res_den;
  wire [1:0] order, status;

  rational_arith_unit dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  frac_op_t  pending_ops[$];
  frac_res_t expected_res[$];
  int errors = 0, n_sent = 0, n_checked = 0;
  int hold_off = 0;

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t reduce_fraction(frac_op_t it);
    frac_res_t r;
    logic signed [63:0] an, bn, ad, bd, n, d, l, rr;
    logic [63:0] nm, dm, g, lim;
    bit neg;
    r = '{0, 0, ORD_LT, ST_OK};
    an = $signed(it.an); bn = $signed(it.bn);
    ad = {33'd0, it.ad}; bd = {33'd0, it.bd};
    lim = 64'd1 << 31;
    if (it.op == OP_CMP) begin
      l = an * bd;
      rr = bn * ad;
      r.ord = (l < rr) ? ORD_LT : (l == rr) ? ORD_EQ : ORD_GT;
      return r;
    end
    if (it.op > OP_CMP) return r;
    if (ad == 0 || bd == 0 || (it.op == OP_DIV && bn == 0)) begin
      r.st = ST_DIVZ;
      return r;
    end
    case (it.op)
      OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
      OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
      OP_MUL: begin n = an * bn; d = ad * bd; end
      default: begin n = an * bd; d = ad * bn; end
    endcase
    neg = (n < 0) != (d < 0);
    nm = n < 0 ? -n : n;
    dm = d < 0 ? -d : d;
    g = gcd64(nm, dm);
    if (g == 0) g = 1;
    nm = nm / g;
    dm = dm / g;
    if (nm == 0) begin
      neg = 0;
      dm = 1;
    end
    if (dm > lim - 1 || (neg ? nm > lim : nm > lim - 1)) begin
      r.st = ST_OVF;
      return r;
    end
    r.num = neg ? -nm[31:0] : nm[31:0];
    r.den = dm[30:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s at result %0d: got %h, want %h", what, n_checked, got, want);
    errors++;
  endtask

  // no-transfer flag as sampled at the last rising edge (low tells the driver a transfer happened)
  logic in_stall_s = 1;
  always @(posedge clk) in_stall_s <= !(in_valid && !in_stall) ;

  // driver: one transfer at a time, random gap before each item
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (in_valid && !in_stall_s) begin
      in_valid <= 0;
      in_gap <= $urandom_range(0, 18) * ($urandom_range(0, 3) != 0);
    end else if (!in_valid && in_gap > 0) begin
      in_gap <= in_gap - 1;
    end else if (!in_valid && pending_ops.size() > 0) begin
      frac_op_t it;
      it = pending_ops.pop_front();
      operation <= it.op; a_num <= it.an; a_den <= it.ad;
      b_num <= it.bn; b_den <= it.bd;
      in_valid <= 1;
      expected_res.push_back(reduce_fraction(it));
    end
  end

  // monitor and receiver stall
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_checked++;
      if (expected_res.size() == 0) begin
        $display("unexpected result %0d", n_checked);
        errors++;
      end else begin
        frac_res_t e;
        e = expected_res.pop_front();
        if (res_num !== e.num) report_mismatch("res_num", res_num, e.num);
        if (res_den !== e.den) report_mismatch("res_den", 32'(res_den), 32'(e.den));
        if (order !== e.ord) report_mismatch("order", 32'(order), 32'(e.ord));
        if (status !== e.st) report_mismatch("status", 32'(status), 32'(e.st));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else if (out_gap > 0) begin
      out_stall <= 1;
      out_gap <= out_gap - 1;
    end else begin
      out_stall <= 0;
      if (out_valid) out_gap <= $urandom_range(0, 18) * ($urandom_range(0, 3) != 0);
    end
  end

  function automatic logic [31:0] pick_num();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 40) - 20;
      3: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(0, 5))
      0: return 31'h7fff_ffff;
      1: return 31'($urandom_range(1, 12));
      2: return 31'($urandom_range(1, 5000));
      3: return ($urandom_range(0, 30) == 0) ? 31'd0 : 31'd1;
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic push_op(logic [2:0] op, logic [31:0] an, logic [30:0] ad,
                         logic [31:0] bn, logic [30:0] bd);
    pending_ops.push_back('{op, an, ad, bn, bd});
    n_sent++;
  endtask

  initial begin
    logic [31:0] x;
    logic [30:0] y;
    repeat (6) @(posedge clk);
    rst <= 0;
    // directed: extremes, every op, zero result, divide by zero, zero den,
    // overflow, unused codes
    push_op(OP_ADD, 1, 2, 1, 3);
    push_op(OP_SUB, 1, 2, 1, 2);
    push_op(OP_MUL, 32'h8000_0000, 1, -1, 1);
    push_op(OP_DIV, 3, 4, 0, 5);
    push_op(OP_DIV, -6, 4, 3, 8);
    push_op(OP_CMP, 1, 3, 2, 6);
    push_op(OP_CMP, -1, 3, 1, 3);
    push_op(OP_CMP, 5, 0, 1, 0);
    push_op(OP_ADD, 1, 0, 1, 1);
    push_op(OP_MUL, 1, 2, 3, 0);
    push_op(OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
    push_op(OP_SUB, 32'h8000_0000, 1, 32'h8000_0000, 1);
    push_op(OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    push_op(OP_DIV, 1, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    push_op(OP_MUL, 0, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    push_op(OP_CMP, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    push_op(3'd5, 1, 1, 1, 1);
    push_op(3'd6, 32'hffff_ffff, 31'h7fff_ffff, 2, 2);
    push_op(3'd7, 32'h5555_5555, 31'h2aaa_aaaa, 32'haaaa_aaaa, 31'h5555_5555);
    push_op(OP_SUB, 32'h8000_0000, 2, 1, 2);
    push_op(OP_DIV, 32'h7fff_ffff, 31'h7fff_fffe, 32'h7fff_ffff, 31'h7fff_ffff);
    for (int i = 0; i < 1000; i++) begin
      x = pick_num();
      y = pick_den();
      push_op(($urandom_range(0, 20) == 0) ? 3'($urandom_range(5, 7))
              : 3'($urandom_range(0, 4)), x, y, pick_num(), pick_den());
      if (i == 300) begin
        // let the block fill while the output is held
        wait (pending_ops.size() < 250);
        hold_off = 600;
      end
    end
    wait (pending_ops.size() == 0 && !in_valid && expected_res.size() == 0);
    repeat (400) @(posedge clk);
    $display("run sent %0d items and checked %0d results", n_sent, n_checked);
    $display("covered all five operations, unused codes and error cases");
    if (errors == 0 && expected_res.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #12ms;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire
